[sv/cpsm_pkg.sv]
package cpsm_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_LEFT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_RIGHT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_TOP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_BOTTOM = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOUR_MODE   = 3'd5;

    localparam int CHAN_BITS  = 8;
    localparam int PIX_BITS   = 10;
    localparam int SUM_BITS   = 21;
    localparam int SHIFT_BITS = 7;
    localparam int MEAN_BITS  = 29;
    localparam int IN_W       = 3 * CHAN_BITS;
    localparam int OUT_W      = 40;

    localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;
    localparam logic [MEAN_BITS-1:0] MEAN_MAX = '1;

    typedef struct packed {
        logic clear;
        logic clear_both;
        logic accept;
        logic scan_start;
        logic scan_run;
        logic div_start;
        logic update;
        logic next_pass;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic shift_ok;
        logic pass1;
        logic scan_done;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

[sv/cpsm_ram.sv]
module cpsm_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/cpsm_div.sv]
module cpsm_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   part;
    logic [DEN_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        part      = {rem_reg, quo_reg[NUM_W-1]};
        trial     = part - {1'b0, den_reg};
        if (start) begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (part >= {1'b0, den_reg}) begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = part[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

[sv/cpsm_datapath.sv]
module cpsm_datapath #(
    parameter int MAX_COLS      = 2048,
    parameter int SHIFT_RANGE   = 40,
    parameter int MAX_ROWS      = 2048,
    parameter int FRACTION_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [cpsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cpsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [cpsm_pkg::IN_W-1:0]        s_tdata,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [cpsm_pkg::OUT_W-1:0]       m_tdata,
    input  cpsm_pkg::cmd_t                   cmd,
    output cpsm_pkg::sts_t                   sts
);
    import cpsm_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CNT_W = COL_W + 1;
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int SH_W  = $clog2(SHIFT_RANGE + 1);
    localparam int SUM_W = CNT_W + SUM_BITS;
    localparam int NUM_W = SUM_W + FRACTION_BITS;
    localparam int MX1   = (CNT_W > ROW_W) ? CNT_W : ROW_W;
    localparam int CMP_W = ((MX1 > CFG_DATA_W) ? MX1 : CFG_DATA_W) + 1;
    localparam int MW    = ((NUM_W > MEAN_BITS) ? NUM_W : MEAN_BITS) + 1;

    // configuration
    logic [11:0] frame_width_reg;
    logic [10:0] region_left_reg;
    logic [11:0] region_right_reg;
    logic [10:0] region_top_reg;
    logic [11:0] region_bottom_reg;
    logic        colour_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= 12'd640;
            region_left_reg   <= 11'd0;
            region_right_reg  <= 12'd640;
            region_top_reg    <= 11'd0;
            region_bottom_reg <= 12'd480;
            colour_mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata;
                REG_REGION_LEFT:   region_left_reg   <= cfg_wdata[10:0];
                REG_REGION_RIGHT:  region_right_reg  <= cfg_wdata;
                REG_REGION_TOP:    region_top_reg    <= cfg_wdata[10:0];
                REG_REGION_BOTTOM: region_bottom_reg <= cfg_wdata;
                REG_COLOUR_MODE:   colour_mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // profile width, capped at the profile depth
    logic [CMP_W-1:0] w_raw;
    logic [CNT_W-1:0] prof_w;
    always_comb begin
        w_raw = CMP_W'(region_right_reg) - CMP_W'(region_left_reg);
        if (CMP_W'(region_right_reg) <= CMP_W'(region_left_reg)) begin
            prof_w = '0;
        end else if (w_raw > CMP_W'(MAX_COLS)) begin
            prof_w = CNT_W'(MAX_COLS);
        end else begin
            prof_w = w_raw[CNT_W-1:0];
        end
    end

    // bank roles: bank_sel 0 means bank a holds the current profile
    logic bank_sel_reg;
    logic [SUM_BITS-1:0] qa, qb, cur_q, prev_q;
    logic we_a, we_b;
    logic [COL_W-1:0] wa_a, wa_b, ra_a, ra_b, cur_ra, prev_ra;
    logic [SUM_BITS-1:0] wd_a, wd_b;

    assign cur_q  = bank_sel_reg ? qb : qa;
    assign prev_q = bank_sel_reg ? qa : qb;

    // pixel position
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CMP_W-1:0] col_inc;
    logic             in_region;
    logic [COL_W-1:0] pix_idx;
    logic [PIX_BITS-1:0] pix_val;

    assign col_inc = CMP_W'(col_reg) + 1'b1;
    assign in_region = (CMP_W'(row_reg) < CMP_W'(MAX_ROWS))
                    && (CMP_W'(row_reg) >= CMP_W'(region_top_reg))
                    && (CMP_W'(row_reg) < CMP_W'(region_bottom_reg))
                    && (CMP_W'(col_reg) >= CMP_W'(region_left_reg))
                    && (CMP_W'(col_reg) < CMP_W'(region_right_reg));
    assign pix_idx = col_reg - COL_W'(region_left_reg);
    assign pix_val = colour_mode_reg
        ? PIX_BITS'(s_tdata[7:0]) + PIX_BITS'(s_tdata[15:8]) + PIX_BITS'(s_tdata[23:16])
        : PIX_BITS'(s_tdata[7:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            if (cmd.load_out) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (col_inc >= CMP_W'(frame_width_reg) || col_inc >= CMP_W'(MAX_COLS)) begin
                col_reg <= '0;
                if (CMP_W'(row_reg) < CMP_W'(MAX_ROWS)) begin
                    row_reg <= row_reg + 1'b1;
                end
            end else begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end else if (cmd.load_out) begin
            col_reg <= '0;
            row_reg <= '0;
        end
    end

    // accumulate: read at accept, add and write in the following cycle
    logic                acc_v_reg;
    logic [COL_W-1:0]    acc_idx_reg;
    logic [PIX_BITS-1:0] acc_val_reg;
    logic                wr_v_reg;
    logic [COL_W-1:0]    wr_idx_reg;
    logic [SUM_BITS-1:0] wr_data_reg;
    logic [SUM_BITS-1:0] acc_base;
    logic [SUM_BITS:0]   acc_sum;
    logic [SUM_BITS-1:0] acc_sat;

    assign acc_base = (wr_v_reg && wr_idx_reg == acc_idx_reg) ? wr_data_reg : cur_q;
    assign acc_sum  = {1'b0, acc_base} + (SUM_BITS + 1)'(acc_val_reg);
    assign acc_sat  = acc_sum[SUM_BITS] ? SUM_MAX : acc_sum[SUM_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_v_reg <= 1'b0;
            wr_v_reg  <= 1'b0;
        end else begin
            acc_v_reg <= cmd.accept && in_region;
            wr_v_reg  <= acc_v_reg;
        end
        acc_idx_reg <= pix_idx;
        acc_val_reg <= pix_val;
        wr_idx_reg  <= acc_idx_reg;
        wr_data_reg <= acc_sat;
    end

    // clearing sweep
    logic [COL_W-1:0] clr_reg;
    logic             clr_last;
    assign clr_last = (CNT_W'(clr_reg) == CNT_W'(MAX_COLS - 1));
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear) begin
            clr_reg <= clr_last ? '0 : clr_reg + 1'b1;
        end
    end

    // shift search
    logic             pass_reg;
    logic [SH_W-1:0]  sh_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] n_len;
    logic             issue;
    logic             rd_v_reg, ad_v_reg;
    logic [SUM_BITS-1:0] ad_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [COL_W-1:0] k_lo, k_off;

    assign n_len = prof_w - CNT_W'(sh_reg);
    assign issue = cmd.scan_run && (k_reg < n_len);
    assign k_lo  = k_reg[COL_W-1:0];
    assign k_off = k_reg[COL_W-1:0] + COL_W'(sh_reg);

    always_comb begin
        if (pass_reg) begin
            cur_ra  = k_off;
            prev_ra = k_lo;
        end else begin
            cur_ra  = k_lo;
            prev_ra = k_off;
        end
        if (!cmd.scan_run) begin
            cur_ra = pix_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            ad_v_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            rd_v_reg <= 1'b0;
            ad_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= issue;
            ad_v_reg <= rd_v_reg;
        end
        if (cmd.scan_start) begin
            k_reg   <= '0;
            acc_reg <= '0;
        end else begin
            if (issue) begin
                k_reg <= k_reg + 1'b1;
            end
            if (ad_v_reg) begin
                acc_reg <= acc_reg + SUM_W'(ad_reg);
            end
        end
        ad_reg <= (cur_q > prev_q) ? cur_q - prev_q : prev_q - cur_q;
    end

    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    cpsm_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     ({acc_reg, {FRACTION_BITS{1'b0}}}),
        .den     (n_len),
        .done    (div_done),
        .quo     (div_quo)
    );

    // best tracking
    logic                  have_reg;
    logic [NUM_W-1:0]      best_reg;
    logic [SHIFT_BITS-1:0] best_s_reg;
    logic [SHIFT_BITS-1:0] s7;

    assign s7 = SHIFT_BITS'(sh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_reg   <= 1'b0;
            sh_reg     <= '0;
            have_reg   <= 1'b0;
            best_reg   <= '0;
            best_s_reg <= '0;
        end else if (cmd.load_out) begin
            pass_reg   <= 1'b0;
            sh_reg     <= '0;
            have_reg   <= 1'b0;
            best_reg   <= '0;
            best_s_reg <= '0;
        end else if (cmd.next_pass) begin
            pass_reg <= 1'b1;
            sh_reg   <= SH_W'(1);
        end else if (cmd.update) begin
            sh_reg <= sh_reg + 1'b1;
            if (!have_reg || div_quo < best_reg) begin
                have_reg   <= 1'b1;
                best_reg   <= div_quo;
                best_s_reg <= pass_reg ? s7 : SHIFT_BITS'(0) - s7;
            end
        end
    end

    // result register
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic [MW-1:0]         best_ext;
    logic [MEAN_BITS-1:0]  mean_sat;

    assign best_ext = MW'(best_reg);
    assign mean_sat = (best_ext > MW'(MEAN_MAX)) ? MEAN_MAX : best_ext[MEAN_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {{(OUT_W - MEAN_BITS - SHIFT_BITS){1'b0}}, mean_sat, best_s_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_sel_reg <= 1'b0;
        end else if (cmd.load_out) begin
            bank_sel_reg <= ~bank_sel_reg;
        end
    end

    // bank ports
    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        wa_a = wr_idx_reg;
        wa_b = wr_idx_reg;
        wd_a = acc_sat;
        wd_b = acc_sat;
        if (cmd.clear) begin
            we_a = cmd.clear_both || !bank_sel_reg;
            we_b = cmd.clear_both || bank_sel_reg;
            wa_a = clr_reg;
            wa_b = clr_reg;
            wd_a = '0;
            wd_b = '0;
        end else if (acc_v_reg) begin
            we_a = !bank_sel_reg;
            we_b = bank_sel_reg;
            wa_a = acc_idx_reg;
            wa_b = acc_idx_reg;
        end
        ra_a = bank_sel_reg ? prev_ra : cur_ra;
        ra_b = bank_sel_reg ? cur_ra : prev_ra;
    end

    cpsm_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_COLS)) u_bank_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (wa_a),
        .wdata (wd_a),
        .raddr (ra_a),
        .rdata (qa)
    );

    cpsm_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_COLS)) u_bank_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (wa_b),
        .wdata (wd_b),
        .raddr (ra_b),
        .rdata (qb)
    );

    always_comb begin
        sts.clr_done  = cmd.clear && clr_last;
        sts.shift_ok  = (CMP_W'(sh_reg) < CMP_W'(SHIFT_RANGE))
                     && (CMP_W'(sh_reg) < CMP_W'(prof_w));
        sts.pass1     = pass_reg;
        sts.scan_done = (k_reg >= n_len) && !rd_v_reg && !ad_v_reg;
        sts.div_done  = div_done;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

[sv/cpsm_ctrl.sv]
module cpsm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tlast,
    output logic           s_tready,
    input  cpsm_pkg::sts_t sts,
    output cpsm_pkg::cmd_t cmd
);
    import cpsm_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_RUN    = 7'b0000010,
        ST_DRAIN  = 7'b0000100,
        ST_SHIFT  = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   both_reg, both_next;

    always_comb begin
        state_next = state_reg;
        both_next  = both_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cmd.clear_both = both_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_done) begin
                    both_next  = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last pixel's write lands this cycle
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (sts.shift_ok) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else if (!sts.pass1) begin
                    cmd.next_pass = 1'b1;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.update = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                both_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            both_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            both_reg  <= both_next;
        end
    end
endmodule

[sv/column_profile_shift_matcher.sv]
// pixels: one beat per cycle while a frame streams in
// after the frame-end beat: a search over the tried shifts s, each scanning W - s
// column pairs through the single read port per profile bank and then running the
// bit-serial divider; then a clear of the newly current profile bank
// reset: synchronous active-low aresetn; afterwards both profile banks are cleared,
// one row per cycle, with s_tready low
module column_profile_shift_matcher #(
    parameter int MAX_COLS      = 2048,
    parameter int SHIFT_RANGE   = 40,
    parameter int MAX_ROWS      = 2048,
    parameter int FRACTION_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cpsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cpsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cpsm_pkg::IN_W-1:0]       s_tdata,   // chan_a, chan_b, chan_c
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cpsm_pkg::OUT_W-1:0]      m_tdata    // best_shift, mean_abs_diff, zero pad
);
    import cpsm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cpsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpsm_datapath #(
        .MAX_COLS      (MAX_COLS),
        .SHIFT_RANGE   (SHIFT_RANGE),
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule
